// ===== rtl/core/pnf_pkg.sv =====
// shared types and constants for the number formatter
// no dependencies
`default_nettype none

package pnf_pkg;

    localparam int VALUE_WIDTH = 32;
    // only the low 32 bits of the value field ever arrive
    localparam int EFF_WIDTH   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int DEC_DIGITS  = ((EFF_WIDTH * 1233) >> 12) + 1;
    localparam int HEX_DIGITS  = (EFF_WIDTH + 3) / 4;
    localparam int MAX_DIGITS  = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_W       = MAX_DIGITS * 4;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W       = $clog2(EFF_WIDTH);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_LO_D  = 8'h64;
    localparam logic [7:0] CHAR_UP_D  = 8'h44;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_LO_B  = 8'h62;
    localparam logic [7:0] CHAR_UP_B  = 8'h42;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [3:0] NIBBLE_MAX = 4'hF;

    typedef struct packed {
        logic        mode;
        logic [7:0]  ch;
        logic [31:0] value;
    } pnf_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } pnf_out_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_SINGLE,
        KIND_DEC,
        KIND_HEX
    } pnf_kind_t;

    typedef enum logic [1:0] {
        SEL_SINGLE,
        SEL_ZERO,
        SEL_X,
        SEL_DIGIT
    } pnf_sel_t;

    typedef struct packed {
        logic     load;
        logic     dabble;
        logic     strip;
        logic     push;
        pnf_sel_t sel;
        logic     last;
    } pnf_cmd_t;

    typedef struct packed {
        pnf_kind_t kind;
        logic      bit_last;
        logic      top_zero;
        logic      cnt_one;
        logic      out_free;
    } pnf_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/printf_number_formatter.sv =====
// top level of the number formatter: controller plus datapath
// depends on pnf_pkg, pnf_ctrl, pnf_datapath
`default_nettype none

// usage
//   s_ channel: one request per item, {mode, ch, value}. mode 0 passes ch on as a
//   single character; mode 1 treats ch as a directive letter (d/D decimal,
//   x/X "0x" plus lowercase hex, b/B backspace, % percent, anything else nothing).
//   m_ channel: one character per transfer, last set on the final one of a run.
//   one item is handled at a time; s_ready drops on acceptance and returns in the
//   cycle the item's final character appears in the output register (after decode if none).
//   steps per item:
//     single character: accept, decode, emit
//     hex: accept, decode, two prefix characters, then MAX_DIGITS strip or digit steps
//     decimal: accept, decode, EFF_WIDTH shift-add-3 steps, then MAX_DIGITS strip or digit
//     steps; the shift-add-3 steps are the one-bit-per-cycle binary to bcd loop in the datapath
//     unknown directive: accept, decode, with no output
//   reset (aresetn low, synchronous) returns the controller to idle and empties the
//   output register; s_ready rises the cycle after reset is released.
//   a stalled receiver holds the character in the output register and the
//   controller waits in place, so nothing is lost or repeated.

module printf_number_formatter
    import pnf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire pnf_in_t  s_payload,
    output logic          m_valid,
    input  wire logic     m_ready,
    output pnf_out_t      m_payload
);

    // command and status between controller and datapath
    pnf_cmd_t    cmd;
    pnf_status_t status;

    pnf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pnf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

    // one item at a time: an accepted request closes the input for the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // a character is only loaded when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> status.out_free)
        else $error("output register overwritten");

    // nothing is emitted in the cycle an item is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !cmd.push)
        else $error("character pushed while idle");

endmodule

`default_nettype wire

// ===== rtl/core/pnf_datapath.sv =====
// datapath: item register, bcd/hex digit shifter, output register
// depends on pnf_pkg
`default_nettype none

module pnf_datapath
    import pnf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire pnf_in_t     s_payload,
    input  wire pnf_cmd_t    cmd,
    output pnf_status_t      status,
    input  wire logic        m_ready,
    output logic             m_valid,
    output pnf_out_t         m_payload
);

    pnf_in_t              item_reg;
    logic [EFF_WIDTH-1:0] val_reg;
    logic [DIG_W-1:0]     dig_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic                 m_valid_reg;
    pnf_out_t             m_payload_reg;

    logic [DIG_W-1:0]     dig_adj;
    logic [3:0]           top_dig;
    logic [7:0]           dig_char;
    logic [7:0]           single_char;
    logic [7:0]           push_char;
    logic                 load_hex;
    pnf_kind_t            item_kind;

    function automatic logic is_hex(input logic [7:0] c);
        return (c == CHAR_X) || (c == CHAR_UP_X);
    endfunction

    assign load_hex = s_payload.mode && is_hex(s_payload.ch);
    assign top_dig  = dig_reg[DIG_W-1 -: 4];

    // add-3 correction per bcd digit ahead of the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (dig_reg[i*4 +: 4] >= 4'd5) begin
                dig_adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            end else begin
                dig_adj[i*4 +: 4] = dig_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        if (top_dig > 4'd9) begin
            dig_char = CHAR_LO_A + {4'd0, top_dig - 4'd10};
        end else begin
            dig_char = CHAR_ZERO + {4'd0, top_dig & NIBBLE_MAX};
        end
    end

    always_comb begin
        if (!item_reg.mode) begin
            single_char = item_reg.ch;
        end else if (item_reg.ch == CHAR_PCT) begin
            single_char = CHAR_PCT;
        end else begin
            single_char = CHAR_BS;
        end
    end

    always_comb begin
        case (cmd.sel)
            SEL_SINGLE: push_char = single_char;
            SEL_ZERO:   push_char = CHAR_ZERO;
            SEL_X:      push_char = CHAR_X;
            SEL_DIGIT:  push_char = dig_char;
            default:    push_char = single_char;
        endcase
    end

    always_comb begin
        if (!item_reg.mode) begin
            item_kind = KIND_SINGLE;
        end else begin
            case (item_reg.ch)
                CHAR_PCT, CHAR_LO_B, CHAR_UP_B: item_kind = KIND_SINGLE;
                CHAR_LO_D, CHAR_UP_D:           item_kind = KIND_DEC;
                CHAR_X, CHAR_UP_X:              item_kind = KIND_HEX;
                default:                        item_kind = KIND_NONE;
            endcase
        end
    end

    assign status.kind     = item_kind;
    assign status.bit_last = (bit_reg == '0);
    assign status.top_zero = (top_dig == 4'd0);
    assign status.cnt_one  = (cnt_reg == CNT_W'(1));
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_payload;
            val_reg  <= s_payload.value[EFF_WIDTH-1:0];
            dig_reg  <= load_hex ? DIG_W'(s_payload.value[EFF_WIDTH-1:0]) : '0;
            cnt_reg  <= CNT_W'(MAX_DIGITS);
            bit_reg  <= BIT_W'(EFF_WIDTH - 1);
        end else if (cmd.dabble) begin
            dig_reg  <= {dig_adj[DIG_W-2:0], val_reg[EFF_WIDTH-1]};
            val_reg  <= {val_reg[EFF_WIDTH-2:0], 1'b0};
            bit_reg  <= bit_reg - BIT_W'(1);
        end else if (cmd.strip || (cmd.push && cmd.sel == SEL_DIGIT)) begin
            dig_reg  <= {dig_reg[DIG_W-5:0], 4'd0};
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_payload_reg.out_char <= push_char;
            m_payload_reg.last     <= cmd.last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pnf_ctrl.sv =====
// controller state machine: sequences decode, conversion, stripping and emission
// depends on pnf_pkg
`default_nettype none

module pnf_ctrl
    import pnf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire pnf_status_t status,
    output pnf_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ONE,
        ST_CONV,
        ST_PFX0,
        ST_PFXX,
        ST_STRIP,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SEL_SINGLE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.kind)
                    KIND_SINGLE: state_next = ST_ONE;
                    KIND_DEC:    state_next = ST_CONV;
                    KIND_HEX:    state_next = ST_PFX0;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_ONE: begin
                if (status.out_free) begin
                    cmd.push   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CONV: begin
                cmd.dabble = 1'b1;
                if (status.bit_last) begin
                    state_next = ST_STRIP;
                end
            end
            ST_PFX0: begin
                if (status.out_free) begin
                    cmd.push   = 1'b1;
                    cmd.sel    = SEL_ZERO;
                    state_next = ST_PFXX;
                end
            end
            ST_PFXX: begin
                if (status.out_free) begin
                    cmd.push   = 1'b1;
                    cmd.sel    = SEL_X;
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (status.top_zero && !status.cnt_one) begin
                    cmd.strip = 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.push = 1'b1;
                    cmd.sel  = SEL_DIGIT;
                    cmd.last = status.cnt_one;
                    if (status.cnt_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = ready_reg;

endmodule

`default_nettype wire

// ===== dv/pnf_tb_pkg.sv =====
`timescale 1ns / 100ps
// character scoreboard for the number formatter testbench
// depends on pnf_pkg for the request and character struct types
package pnf_tb_pkg;
    import pnf_pkg::*;

    localparam logic MODE_LITERAL   = 1'b0;
    localparam logic MODE_DIRECTIVE = 1'b1;

    class char_scoreboard;
        pnf_out_t expected_chars[$];
        int errors;
        int checked;
        int n_literal;
        int n_dec;
        int n_hex;
        int n_single;
        int n_silent;

        function new();
            errors    = 0;
            checked   = 0;
            n_literal = 0;
            n_dec     = 0;
            n_hex     = 0;
            n_single  = 0;
            n_silent  = 0;
        endfunction

        // formats one request into its character run; returns the run length
        function int note_request(pnf_in_t req);
            logic [7:0]  text[$];
            logic [31:0] v;
            logic [3:0]  nib;
            pnf_out_t    c;
            v = req.value;
            if (req.mode == MODE_LITERAL) begin
                text.push_back(req.ch);
                n_literal++;
            end else begin
                case (req.ch)
                    CHAR_PCT: begin
                        text.push_back(CHAR_PCT);
                        n_single++;
                    end
                    CHAR_LO_B, CHAR_UP_B: begin
                        text.push_back(CHAR_BS);
                        n_single++;
                    end
                    CHAR_LO_D, CHAR_UP_D: begin
                        if (v == 0)
                            text.push_back(CHAR_ZERO);
                        while (v != 0) begin
                            text.push_front(CHAR_ZERO + 8'(v % 10));
                            v = v / 10;
                        end
                        n_dec++;
                    end
                    CHAR_X, CHAR_UP_X: begin
                        if (v == 0)
                            text.push_back(CHAR_ZERO);
                        while (v != 0) begin
                            nib = v[3:0] & NIBBLE_MAX;
                            if (nib < 10)
                                text.push_front(CHAR_ZERO + 8'(nib));
                            else
                                text.push_front(CHAR_LO_A + 8'(nib - 10));
                            v = v >> 4;
                        end
                        text.push_front(CHAR_X);
                        text.push_front(CHAR_ZERO);
                        n_hex++;
                    end
                    default: n_silent++;
                endcase
            end
            foreach (text[i]) begin
                c.out_char = text[i];
                c.last     = (i == text.size() - 1);
                expected_chars.push_back(c);
            end
            return text.size();
        endfunction

        function void check_char(pnf_out_t got);
            pnf_out_t want;
            if (expected_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected character %h last %b", $time, got.out_char, got.last);
                return;
            end
            want = expected_chars.pop_front();
            checked++;
            if (got.out_char !== want.out_char) begin
                errors++;
                $display("%0t: out_char expected %h got %h", $time, want.out_char, got.out_char);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %b got %b (char %h)", $time, want.last, got.last,
                         want.out_char);
            end
        endfunction

        function bit idle();
            return expected_chars.size() == 0;
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// top-level testbench for printf_number_formatter: directed and random requests,
// random stalls on both channels. depends on pnf_pkg, pnf_tb_pkg and the rtl
module tb_top;
    import pnf_pkg::*;
    import pnf_tb_pkg::*;

    // worst run is roughly 200 requests, each with a decimal conversion, ten characters behind
    // long receiver stalls and a long sender gap, so this leaves plenty of margin
    localparam int CYCLE_LIMIT  = 400000;
    // a silent directive may still be in flight
    localparam int DRAIN_CYCLES = 64;
    // random requests after the directed ones, about 180 in all
    localparam int RANDOM_ITEMS = 160;
    localparam int STEADY_FROM  = 60;
    localparam int STEADY_TO    = 90;
    localparam int PAUSE_AT     = 120;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    pnf_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    pnf_out_t m_payload;

    char_scoreboard sb;
    bit  steady      = 1'b0;   // no idling on either side while set
    int  cycles      = 0;
    int  stall_left  = 0;
    int  counted     = 0;      // requests accepted so far

    printf_number_formatter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // mostly back to back, sometimes a short gap, rarely a long hold
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic pnf_in_t make_request(logic mode, logic [7:0] ch, logic [31:0] value);
        pnf_in_t req;
        req.mode  = mode;
        req.ch    = ch;
        req.value = value;
        return req;
    endfunction

    // mix: literals, well-formed directives with values of every magnitude, and noise letters
    function automatic pnf_in_t random_request();
        pnf_in_t    req;
        int         r;
        logic [7:0] letter;
        req.value = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 15) == 0)
            req.value = '0;
        else if ($urandom_range(0, 15) == 0)
            req.value = $urandom;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            req.mode = MODE_LITERAL;
            req.ch   = 8'($urandom_range(0, 255));
        end else if (r < 85) begin
            case ($urandom_range(0, 6))
                0: letter = CHAR_LO_D;
                1: letter = CHAR_UP_D;
                2: letter = CHAR_X;
                3: letter = CHAR_UP_X;
                4: letter = CHAR_LO_B;
                5: letter = CHAR_UP_B;
                default: letter = CHAR_PCT;
            endcase
            req.mode = MODE_DIRECTIVE;
            req.ch   = letter;
        end else begin
            req.mode = MODE_DIRECTIVE;
            req.ch   = 8'($urandom_range(0, 255));
        end
        return req;
    endfunction

    // holds valid until the request is taken; valid only drops when a gap follows,
    // so back-to-back requests never lower and raise it in the same step
    task automatic send_request(input pnf_in_t req, input int gap);
        s_valid   <= 1'b1;
        s_payload <= req;
        do
            @(posedge aclk);
        while (!s_ready);
        void'(sb.note_request(req));
        counted++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_all_chars();
        while (!sb.idle())
            @(posedge aclk);
    endtask

    // receiver: random stalls except in the steady stretch
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // every character taken by the receiver is checked against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_char(m_payload);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still expected", cycles,
                     sb.expected_chars.size());
            $display("[printf_number_formatter] ERROR");
            $finish;
        end
    end

    initial begin
        pnf_in_t req;
        int      gap;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: literal extremes, every directive letter, value extremes,
        // unknown letters and a literal that looks like a directive
        send_request(make_request(MODE_LITERAL, 8'h00, 32'h0), pick_gap());
        send_request(make_request(MODE_LITERAL, 8'hFF, 32'hFFFFFFFF), pick_gap());
        send_request(make_request(MODE_LITERAL, 8'h41, 32'h0), pick_gap());
        send_request(make_request(MODE_LITERAL, CHAR_LO_D, 32'd1234), pick_gap());
        send_request(make_request(MODE_LITERAL, CHAR_PCT, 32'h0), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_PCT, 32'hFFFFFFFF), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_LO_B, 32'h0), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_UP_B, 32'h12345678), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_LO_D, 32'd0), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_UP_D, 32'hFFFFFFFF), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_LO_D, 32'd9), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_LO_D, 32'd10), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_UP_D, 32'd1000000000), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_LO_D, 32'd999999999), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_X, 32'h0), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_UP_X, 32'hFFFFFFFF), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_X, 32'hABCDEF09), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_X, 32'h10), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, CHAR_UP_X, 32'h1), pick_gap());
        // unknown letters produce nothing; follow them with printable ones
        send_request(make_request(MODE_DIRECTIVE, 8'h71, 32'd55), pick_gap());
        send_request(make_request(MODE_DIRECTIVE, 8'h00, 32'h0), 0);
        send_request(make_request(MODE_DIRECTIVE, 8'hFF, 32'hFFFFFFFF), 0);
        send_request(make_request(MODE_DIRECTIVE, CHAR_LO_D, 32'd7), pick_gap());

        // random part
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            steady = (counted >= STEADY_FROM) && (counted < STEADY_TO);
            req    = random_request();
            gap    = steady ? 0 : pick_gap();
            if (counted == PAUSE_AT - 1 && gap == 0)
                gap = 1;
            if (counted == RANDOM_ITEMS - 1 && gap == 0)
                gap = 1;
            send_request(req, gap);
            // sender holds off once until the output side has fully drained
            if (counted == PAUSE_AT && gap > 0)
                wait_all_chars();
        end
        // make sure valid is low even if the loop ended on a request with gap 0
        s_valid <= 1'b0;
        steady  = 1'b0;

        wait_all_chars();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d literals, %0d decimal, %0d hex, %0d single-char, %0d silent",
                 sb.n_literal, sb.n_dec, sb.n_hex, sb.n_single, sb.n_silent);
        $display("%0d characters checked in %0d cycles, %0d mismatches", sb.checked, cycles,
                 sb.errors);
        if (sb.errors == 0 && sb.idle())
            $display("[printf_number_formatter] OK");
        else
            $display("[printf_number_formatter] ERROR");
        $finish;
    end

endmodule
